FILE: design/utf8_validating_decoder_top_assert.svh
// assertion macros used by the utf8 decoder checker
`ifndef UTF8_VALIDATING_DECODER_TOP_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define U8D_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

// next-cycle implication, disabled while reset is asserted
`define U8D_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

FILE: design/utf8d_pkg.sv
package utf8d_pkg;

  // sequence lengths held in the pending length register
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN1 = 3'd1;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // code point limits
  localparam logic [20:0] MIN_LEN2  = 21'h000080;
  localparam logic [20:0] MIN_LEN3  = 21'h000800;
  localparam logic [20:0] MIN_LEN4  = 21'h010000;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;

  // byte class masks and patterns
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        well_formed;
    logic [2:0]  bytes_used;
    logic        last_in_run;
  } out_beat_t;

  // results caused by one input byte, slot 0 goes out first
  typedef struct packed {
    out_beat_t [MAX_RES-1:0] ent;
    logic [2:0]              count;
  } res_list_t;

endpackage

FILE: design/utf8_validating_decoder_top.sv
// utf8 validating decoder
// input channel: one beat per text byte, or an end-of-text beat that flushes
// a pending partial sequence. output channel: one beat per code point, with
// well_formed low for fallback bytes and last_in_run high on the final beat
// caused by an input beat. an input beat may cause zero to four output beats.
// an accepted byte waits in the input register, is decoded as it is consumed,
// and its results are registered in the result list that drives the output.
// one byte per cycle while each byte gives at most one result and the receiver
// is ready; a byte giving more results holds the input while the single-beat output port sends them.
// the input register takes one more beat while results wait on a stalled
// receiver; beyond that in_ready_o drops until the list drains.
// reset clears the pending sequence, the input register and the result list;
// held continuation bits are not cleared and are only read once written.
module utf8_validating_decoder_top import utf8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic      in_valid_q, in_valid_d;
  in_beat_t  in_beat_q;
  logic      can_load, consume, accept_in;
  res_list_t list;

  assign consume    = in_valid_q && can_load;
  assign in_ready_o = !in_valid_q || consume;
  assign accept_in  = in_valid_i && in_ready_o;

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    priority if (accept_in) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_beat_q <= in_data_i;
    end
  end

  // byte decode and sequence state
  utf8d_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (consume),
    .beat_i (in_beat_q),
    .list_o (list)
  );

  // result list, one beat out per cycle while the receiver is ready
  utf8d_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume),
    .list_i      (list),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/utf8d_decode.sv
module utf8d_decode import utf8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_beat_t  beat_i,
  output res_list_t list_o
);

  logic [7:0] lead_q, lead_d;
  logic [2:0] exp_len_q, exp_len_d;
  logic [1:0] held_q, held_d;
  logic [5:0] cont_q [2];
  logic [5:0] cont_d [2];

  logic [7:0]  b;
  logic        pending, is_cont, hold_cond, bad_val;
  logic        do_replay, do_fresh, do_fail_byte, do_valid, do_hold;
  logic [20:0] val, min_val;
  logic [2:0]  idx;
  res_list_t   list;

  assign b         = beat_i.data_byte;
  assign pending   = (exp_len_q != SEQ_NONE);
  assign is_cont   = ((b & CONT_MASK) == CONT_PAT);
  assign hold_cond = (({1'b0, held_q} + 3'd2) < exp_len_q) && (held_q < 2'd2);

  // assemble the completed value and its lower bound
  always_comb begin
    unique case (exp_len_q)
      SEQ_LEN2: begin
        val     = {10'd0, lead_q[4:0], b[5:0]};
        min_val = MIN_LEN2;
      end
      SEQ_LEN3: begin
        val     = {5'd0, lead_q[3:0], cont_q[0], b[5:0]};
        min_val = MIN_LEN3;
      end
      default: begin
        val     = {lead_q[2:0], cont_q[0], cont_q[1], b[5:0]};
        min_val = MIN_LEN4;
      end
    endcase
  end

  assign bad_val = (val < min_val) || ((val >= SURR_LO) && (val <= SURR_HI)) ||
                   (val > CP_MAX);

  // pick what this byte does
  always_comb begin
    do_replay    = 1'b0;
    do_fresh     = 1'b0;
    do_fail_byte = 1'b0;
    do_valid     = 1'b0;
    do_hold      = 1'b0;
    priority if (beat_i.end_of_text) begin
      do_replay = pending;
    end else if (!pending) begin
      do_fresh = 1'b1;
    end else if (!is_cont) begin
      do_replay = 1'b1;
      do_fresh  = 1'b1;
    end else if (hold_cond) begin
      do_hold = 1'b1;
    end else if (bad_val) begin
      do_replay    = 1'b1;
      do_fail_byte = 1'b1;
    end else begin
      do_valid = 1'b1;
    end
  end

  // build the result list and the next state
  always_comb begin
    list      = '0;
    idx       = 3'd0;
    lead_d    = lead_q;
    exp_len_d = exp_len_q;
    held_d    = held_q;
    cont_d    = cont_q;

    // replay lead and held continuation bytes as fallback bytes
    if (do_replay) begin
      list.ent[idx[1:0]] = '{code_point: {13'd0, lead_q}, well_formed: 1'b0,
                             bytes_used: SEQ_LEN1, last_in_run: 1'b0};
      idx = idx + 3'd1;
      if (held_q >= 2'd1) begin
        list.ent[idx[1:0]] = '{code_point: {13'd0, 2'b10, cont_q[0]}, well_formed: 1'b0,
                               bytes_used: SEQ_LEN1, last_in_run: 1'b0};
        idx = idx + 3'd1;
      end
      if (held_q >= 2'd2) begin
        list.ent[idx[1:0]] = '{code_point: {13'd0, 2'b10, cont_q[1]}, well_formed: 1'b0,
                               bytes_used: SEQ_LEN1, last_in_run: 1'b0};
        idx = idx + 3'd1;
      end
      exp_len_d = SEQ_NONE;
      held_d    = 2'd0;
    end

    // decode a byte with nothing pending, or the byte that broke a pending sequence
    if (do_fresh) begin
      if (!b[7]) begin
        list.ent[idx[1:0]] = '{code_point: {13'd0, b}, well_formed: 1'b1,
                               bytes_used: SEQ_LEN1, last_in_run: 1'b0};
        idx = idx + 3'd1;
      end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
        lead_d    = b;
        exp_len_d = SEQ_LEN2;
        held_d    = 2'd0;
      end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
        lead_d    = b;
        exp_len_d = SEQ_LEN3;
        held_d    = 2'd0;
      end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
        lead_d    = b;
        exp_len_d = SEQ_LEN4;
        held_d    = 2'd0;
      end else begin
        list.ent[idx[1:0]] = '{code_point: {13'd0, b}, well_formed: 1'b0,
                               bytes_used: SEQ_LEN1, last_in_run: 1'b0};
        idx = idx + 3'd1;
      end
    end

    // final continuation of a bad sequence
    if (do_fail_byte) begin
      list.ent[idx[1:0]] = '{code_point: {13'd0, b}, well_formed: 1'b0,
                             bytes_used: SEQ_LEN1, last_in_run: 1'b0};
      idx = idx + 3'd1;
    end

    // completed sequence
    if (do_valid) begin
      list.ent[idx[1:0]] = '{code_point: val, well_formed: 1'b1,
                             bytes_used: exp_len_q, last_in_run: 1'b0};
      idx       = idx + 3'd1;
      exp_len_d = SEQ_NONE;
      held_d    = 2'd0;
    end

    // hold a middle continuation byte
    if (do_hold) begin
      cont_d[held_q[0]] = b[5:0];
      held_d            = held_q + 2'd1;
    end

    // mark the last result of this beat
    if (idx != 3'd0) begin
      list.ent[idx[1:0] - 2'd1].last_in_run = 1'b1;
    end
    list.count = idx;
  end

  assign list_o = list;

  // pending sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      exp_len_q <= SEQ_NONE;
      held_q    <= '0;
    end else if (fire_i) begin
      lead_q    <= lead_d;
      exp_len_q <= exp_len_d;
      held_q    <= held_d;
    end
  end

  // held continuation bits, no reset
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      cont_q <= cont_d;
    end
  end

endmodule

FILE: design/utf8d_serializer.sv
module utf8d_serializer import utf8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_list_t list_i,
  output logic      can_load_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  out_beat_t [MAX_RES-1:0] ent_q, ent_d;
  logic [2:0]              cnt_q, cnt_d;
  logic                    pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);

  // load a new list or shift the head out
  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    priority if (load_i) begin
      ent_d = list_i.ent;
      cnt_d = list_i.count;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

FILE: design/utf8d_checker.sv
`include "utf8_validating_decoder_top_assert.svh"

module utf8d_checker import utf8d_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_data_o
);

  logic [20:0] cp;
  logic        wf, stall, fb_ok, is_surr, len_ok;
  logic [2:0]  used;

  assign cp      = out_data_o.code_point;
  assign wf      = out_data_o.well_formed;
  assign used    = out_data_o.bytes_used;
  assign stall   = out_valid_o && !out_ready_i;
  assign fb_ok   = (used == SEQ_LEN1) && (cp[20:8] == 13'd0) && cp[7];
  assign is_surr = (cp >= SURR_LO) && (cp <= SURR_HI);
  assign len_ok  = ((used == SEQ_LEN1) == (cp < MIN_LEN2)) &&
                   ((used == SEQ_LEN4) == (cp >= MIN_LEN4));

  // a stalled result holds
  `U8D_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stall, out_valid_o && $stable(out_data_o))

  // fallback beats carry one raw non-ascii byte
  `U8D_ASSERT_IMP(a_fallback, clk_i, rst_ni, out_valid_o && !wf, fb_ok)

  // well-formed code points are scalar values
  `U8D_ASSERT_IMP(a_scalar, clk_i, rst_ni, out_valid_o && wf, (cp <= CP_MAX) && !is_surr)

  // one-byte and four-byte counts match the code point range
  `U8D_ASSERT_IMP(a_len, clk_i, rst_ni, out_valid_o && wf, len_ok)

endmodule

bind utf8_validating_decoder_top utf8d_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: tb/utf8_stream_checker.sv
module utf8_stream_checker import utf8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_beat_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_beat_t   out_data_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);

  // shadow of the pending sequence
  logic [7:0]  lead_q = '0;
  logic [2:0]  len_q  = SEQ_NONE;
  logic [1:0]  held_q = '0;
  logic [5:0]  cont_q [2];

  // code points still to come, oldest first, and those of the current beat
  out_beat_t   cp_expect [$];
  out_beat_t   beat_cps [$];
  int unsigned n_pending = 0;
  int unsigned n_errors  = 0;

  assign pending_o = n_pending;
  assign errors_o  = n_errors;

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    n_errors++;
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic add_cp(input logic [20:0] cp, input logic wf, input logic [2:0] used);
    out_beat_t r;
    r.code_point  = cp;
    r.well_formed = wf;
    r.bytes_used  = used;
    r.last_in_run = 1'b0;
    beat_cps.push_back(r);
  endtask

  // lead and held continuations come back out as raw bytes
  task automatic replay_pending();
    add_cp({13'd0, lead_q}, 1'b0, 3'd1);
    for (int i = 0; i < held_q; i++) add_cp({13'd0, 2'b10, cont_q[i]}, 1'b0, 3'd1);
    len_q  = SEQ_NONE;
    held_q = '0;
  endtask

  // byte seen with nothing pending
  task automatic take_fresh(input logic [7:0] b);
    if (!b[7]) begin
      add_cp({13'd0, b}, 1'b1, 3'd1);
    end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      lead_q = b; len_q = SEQ_LEN2; held_q = '0;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      lead_q = b; len_q = SEQ_LEN3; held_q = '0;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      lead_q = b; len_q = SEQ_LEN4; held_q = '0;
    end else begin
      add_cp({13'd0, b}, 1'b0, 3'd1);
    end
  endtask

  task automatic predict_beat(input in_beat_t beat);
    logic [20:0] val;
    logic [20:0] floor_cp;
    out_beat_t   tail;
    beat_cps.delete();
    if (beat.end_of_text) begin
      if (len_q != SEQ_NONE) replay_pending();
    end else if (len_q == SEQ_NONE) begin
      take_fresh(beat.data_byte);
    end else if ((beat.data_byte & CONT_MASK) != CONT_PAT) begin
      // cut short: replay, then decode the breaking byte on its own
      replay_pending();
      take_fresh(beat.data_byte);
    end else if (held_q + 3'd2 < len_q) begin
      cont_q[held_q[0]] = beat.data_byte[5:0];
      held_q++;
    end else begin
      // sequence complete: assemble and range check
      case (len_q)
        SEQ_LEN2: begin val = {16'd0, lead_q[4:0]}; floor_cp = MIN_LEN2; end
        SEQ_LEN3: begin val = {17'd0, lead_q[3:0]}; floor_cp = MIN_LEN3; end
        default:  begin val = {18'd0, lead_q[2:0]}; floor_cp = MIN_LEN4; end
      endcase
      for (int i = 0; i < held_q; i++) val = {val[14:0], cont_q[i]};
      val = {val[14:0], beat.data_byte[5:0]};
      if (val < floor_cp || (val >= SURR_LO && val <= SURR_HI) || val > CP_MAX) begin
        replay_pending();
        add_cp({13'd0, beat.data_byte}, 1'b0, 3'd1);
      end else begin
        add_cp(val, 1'b1, len_q);
        len_q  = SEQ_NONE;
        held_q = '0;
      end
    end
    if (beat_cps.size() > 0) begin
      tail = beat_cps[beat_cps.size()-1];
      tail.last_in_run = 1'b1;
      beat_cps[beat_cps.size()-1] = tail;
    end
    foreach (beat_cps[i]) cp_expect.push_back(beat_cps[i]);
  endtask

  task automatic check_beat(input out_beat_t got);
    out_beat_t want;
    if (cp_expect.size() == 0) begin
      flag_mismatch("unexpected beat, code_point", got.code_point, 0);
    end else begin
      want = cp_expect.pop_front();
      if (got.code_point !== want.code_point)
        flag_mismatch("code_point", got.code_point, want.code_point);
      if (got.well_formed !== want.well_formed)
        flag_mismatch("well_formed", got.well_formed, want.well_formed);
      if (got.bytes_used !== want.bytes_used)
        flag_mismatch("bytes_used", got.bytes_used, want.bytes_used);
      if (got.last_in_run !== want.last_in_run)
        flag_mismatch("last_in_run", got.last_in_run, want.last_in_run);
    end
  endtask

  // predict on every accepted input beat, compare every accepted output beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q = '0;
      len_q  = SEQ_NONE;
      held_q = '0;
      cp_expect.delete();
    end else begin
      if (in_valid_i && in_ready_i) predict_beat(in_data_i);
      if (out_valid_i && out_ready_i) check_beat(out_data_i);
    end
    n_pending = cp_expect.size();
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  import utf8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned TAIL_CYCLES = 20;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  int unsigned cp_pending;
  int unsigned mismatches;
  int unsigned beats_sent = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned snd_idle   = 0;
  int unsigned rx_idle    = 0;
  logic        rx_hold    = 1'b0;

  utf8_validating_decoder_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  utf8_stream_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .pending_o   (cp_pending),
    .errors_o    (mismatches)
  );

  always #5 clk = ~clk;

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
        @(posedge clk);
      end
    end
  end

  // offer one beat, with optional idle gap, and wait until it is taken
  task automatic send_beat(input logic [7:0] b, input logic eot);
    in_beat_t beat;
    beat.data_byte   = b;
    beat.end_of_text = eot;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(b, 1'b0);
  endtask

  // stop offering until every expected code point has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (cp_pending != 0);
    @(posedge clk);
  endtask

  // well-formed encoding of a scalar value
  task automatic send_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      send_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      send_byte({3'b110, cp[10:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      send_byte({4'b1110, cp[15:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end else begin
      send_byte({5'b11110, cp[20:18]});
      send_byte({2'b10, cp[17:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end
  endtask

  function automatic logic [7:0] pick_lead(input int unsigned n);
    logic [7:0] b;
    // half the time a lead near a range boundary
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(10))
        0:       b = 8'hC0;
        1:       b = 8'hC1;
        2:       b = 8'hC2;
        3:       b = 8'hDF;
        4:       b = 8'hE0;
        5:       b = 8'hED;
        6:       b = 8'hEF;
        7:       b = 8'hF0;
        8:       b = 8'hF4;
        9:       b = 8'hF5;
        default: b = 8'hF7;
      endcase
    end else if (n == 2) begin
      b = 8'hC0 | 8'($urandom_range(31));
    end else if (n == 3) begin
      b = 8'hE0 | 8'($urandom_range(15));
    end else begin
      b = 8'hF0 | 8'($urandom_range(7));
    end
    return b;
  endfunction

  function automatic int unsigned lead_length(input logic [7:0] b);
    if ((b & LEAD2_MASK) == LEAD2_PAT) return 2;
    if ((b & LEAD3_MASK) == LEAD3_PAT) return 3;
    return 4;
  endfunction

  task automatic send_random_unit();
    int unsigned kind;
    int unsigned n;
    logic [20:0] cp;
    logic [7:0]  lead;
    kind = $urandom_range(99);
    if (kind < 45) begin
      // valid scalar of random length
      case ($urandom_range(3))
        0:       cp = 21'($urandom_range(21'h7F));
        1:       cp = 21'($urandom_range(21'h7FF, 21'h80));
        2: begin
          cp = 21'($urandom_range(21'hFFFF, 21'h800));
          if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h1000;
        end
        default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
      endcase
      send_cp(cp);
    end else if (kind < 65) begin
      // full-length sequence, random content, often out of range
      lead = pick_lead($urandom_range(4, 2));
      n = lead_length(lead);
      send_byte(lead);
      repeat (n - 1) send_byte(8'h80 | 8'($urandom_range(63)));
    end else if (kind < 78) begin
      // sequence cut short by whatever follows
      lead = pick_lead($urandom_range(4, 2));
      n = lead_length(lead);
      send_byte(lead);
      repeat ($urandom_range(n - 2)) send_byte(8'h80 | 8'($urandom_range(63)));
    end else if (kind < 86) begin
      send_beat(8'($urandom_range(255)), 1'b1);
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = beats_sent + count;
    while (beats_sent < target) send_random_unit();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sender light, receiver heavy
    snd_idle = 33;
    rx_idle  = 78;

    // lowest ascii byte, invalid lead, stray continuation
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    // valid 2-byte and highest valid 4-byte
    send_byte(8'hC2); send_byte(8'hA9);
    send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
    // overlong two-byte encoding of zero
    send_byte(8'hC0); send_byte(8'h80);
    // surrogate
    send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
    // above the code space, four fallback bytes
    send_byte(8'hF4); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
    // cut short by an ascii byte
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'h41);
    // end of text with a partial sequence, then with nothing pending
    send_byte(8'hF0); send_byte(8'h9F); send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);

    run_random(33);
    wait_drain();

    // sender heavy, receiver light
    snd_idle = 78;
    rx_idle  = 33;
    run_random(33);
    wait_drain();

    // full rate
    snd_idle = 0;
    rx_idle  = 0;
    run_random(33);

    // receiver holds off while beats giving four results keep coming
    rx_hold = 1'b1;
    repeat (6) begin
      send_byte(8'hF4); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
    end
    wait_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
